### rtl/vbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vbd_pkg;

    localparam int LBL_W      = 8;
    localparam int CNT_W      = 10;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 3;

    // Largest count that fits the counter width.
    localparam int WIDTH_CAP  = 1023;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_OCCUPIED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_THROUGH = 1'd1;

    typedef struct packed {
        logic             pass;
        logic             last;
        logic             occ;
        logic [LBL_W-1:0] label;
    } stage_t;

    typedef struct packed {
        logic [CNT_W-1:0] occupied_total;
        logic [LBL_W-1:0] coarse_label;
        logic             coarse_occupied;
    } result_t;

endpackage
`default_nettype wire

### rtl/vbd_vote_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module vbd_vote_ram #(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8,
    parameter int DW    = 10
) (
    input  wire logic             aclk,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_idx,
    output logic      [DW-1:0]    rd_data,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire logic [DW-1:0]    wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/vbd_tally.sv
`timescale 1ns / 1ps
`default_nettype none
module vbd_tally #(
    parameter int MAX_BLOCK_VOXELS = 512,
    parameter int NUM_LABELS       = 256,
    parameter int IDX_W            = 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [vbd_pkg::CNT_W-1:0]    min_occupied,
    input  wire logic                         s1_valid,
    input  wire vbd_pkg::stage_t              s1,
    input  wire logic [vbd_pkg::CNT_W-1:0]    rd_data,
    output logic                              wr_en,
    output logic      [IDX_W-1:0]             wr_idx,
    output logic      [vbd_pkg::CNT_W-1:0]    wr_data,
    output logic                              res_valid,
    output vbd_pkg::result_t                  res
);

    localparam int CAP = (MAX_BLOCK_VOXELS < vbd_pkg::WIDTH_CAP) ?
                         MAX_BLOCK_VOXELS : vbd_pkg::WIDTH_CAP;
    localparam logic [vbd_pkg::CNT_W-1:0] CAP_V = vbd_pkg::CNT_W'(CAP);

    logic [NUM_LABELS-1:0]       valid_reg, valid_next;
    logic [vbd_pkg::CNT_W-1:0]   occ_cnt_reg, occ_cnt_next;
    logic [vbd_pkg::CNT_W-1:0]   best_cnt_reg, best_cnt_next;
    logic [vbd_pkg::LBL_W-1:0]   best_lbl_reg, best_lbl_next;
    logic                        fwd_valid_reg, fwd_valid_next;
    logic [IDX_W-1:0]            fwd_idx_reg;
    logic [vbd_pkg::CNT_W-1:0]   fwd_cnt_reg;

    logic [IDX_W-1:0]            idx;
    logic                        vote;
    logic                        block_end;
    logic [vbd_pkg::CNT_W-1:0]   cur;
    logic [vbd_pkg::CNT_W-1:0]   cnt_new;
    logic [vbd_pkg::CNT_W-1:0]   occ_new;
    logic [vbd_pkg::CNT_W-1:0]   best_cnt_new;
    logic [vbd_pkg::LBL_W-1:0]   best_lbl_new;

    always_comb begin
        idx       = s1.label[IDX_W-1:0];
        vote      = s1_valid && !s1.pass && s1.occ && (s1.label != '0) &&
                    ({1'b0, s1.label} < (vbd_pkg::LBL_W + 1)'(NUM_LABELS));
        block_end = s1_valid && !s1.pass && s1.last;

        // The write of the previous cycle is not yet visible in the read data.
        if (fwd_valid_reg && (fwd_idx_reg == idx)) begin
            cur = fwd_cnt_reg;
        end else if (valid_reg[idx]) begin
            cur = rd_data;
        end else begin
            cur = '0;
        end
        cnt_new = cur + 1'b1;

        wr_en   = vote && (cur < CAP_V);
        wr_idx  = idx;
        wr_data = cnt_new;

        occ_new = occ_cnt_reg;
        if (s1_valid && !s1.pass && s1.occ && (occ_cnt_reg < CAP_V)) begin
            occ_new = occ_cnt_reg + 1'b1;
        end

        best_cnt_new = best_cnt_reg;
        best_lbl_new = best_lbl_reg;
        if (wr_en && ((cnt_new > best_cnt_reg) ||
                      ((cnt_new == best_cnt_reg) && (s1.label < best_lbl_reg)))) begin
            best_cnt_new = cnt_new;
            best_lbl_new = s1.label;
        end

        valid_next     = valid_reg;
        occ_cnt_next   = occ_new;
        best_cnt_next  = best_cnt_new;
        best_lbl_next  = best_lbl_new;
        if (wr_en) begin
            valid_next[idx] = 1'b1;
        end
        if (block_end) begin
            valid_next    = '0;
            occ_cnt_next  = '0;
            best_cnt_next = '0;
            best_lbl_next = '0;
        end
        fwd_valid_next = wr_en && !block_end;

        res_valid = s1_valid && (s1.pass || s1.last);
        if (s1.pass) begin
            res.coarse_occupied = s1.occ;
            res.coarse_label    = s1.label;
            res.occupied_total  = vbd_pkg::CNT_W'(s1.occ);
        end else begin
            res.coarse_occupied = (occ_new >= min_occupied);
            res.coarse_label    = best_lbl_new;
            res.occupied_total  = occ_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            occ_cnt_reg   <= '0;
            best_cnt_reg  <= '0;
            best_lbl_reg  <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            occ_cnt_reg   <= occ_cnt_next;
            best_cnt_reg  <= best_cnt_next;
            best_lbl_reg  <= best_lbl_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_idx_reg <= idx;
        fwd_cnt_reg <= cnt_new;
    end

endmodule
`default_nettype wire

### rtl/vbd_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module vbd_out_fifo (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push,
    input  wire vbd_pkg::result_t              push_data,
    input  wire logic                          pop,
    output logic                               not_empty,
    output vbd_pkg::result_t                   head,
    output logic      [vbd_pkg::Q_CNT_W-1:0]   count
);

    vbd_pkg::result_t              entries [vbd_pkg::Q_DEPTH];
    logic [vbd_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [vbd_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [vbd_pkg::Q_CNT_W-1:0]   count_reg, count_next;
    logic                          do_pop;

    always_comb begin
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + vbd_pkg::Q_CNT_W'(push) - vbd_pkg::Q_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];
    assign count     = count_reg;

endmodule
`default_nettype wire

### rtl/voxel_block_downsample_mode.sv
`timescale 1ns / 1ps
`default_nettype none
// Majority-vote block downsampler. Fine voxels of a coarse block stream in on the s_ channel
// with s_tlast on the block's last voxel; one coarse cell leaves on the m_ channel per block
// (or one per voxel in pass-through mode). The block accepts one voxel every cycle while the
// four-entry result queue has room. On its way to the queue each voxel passes first through
// the read of its label's vote count from the single-read, single-write vote RAM, then through
// the increment, write-back and best-label update, with the write of the previous cycle
// forwarded to a following voxel of the same label. Vote counts are cleared at block end
// through one valid flag per label, so there is no clearing pass and no gap between blocks.
// Configuration: cfg_index 0 is min_occupied, 1 is pass_through; write only while idle.
module voxel_block_downsample_mode #(
    parameter int MAX_BLOCK_VOXELS = 512,
    parameter int NUM_LABELS       = 256
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [vbd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [vbd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [0] occupied, [8:1] label, [15:9] zero
    input  wire logic [vbd_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [0] coarse_occupied, [8:1] coarse_label, [18:9] occupied_total, [23:19] zero
    output logic      [vbd_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int IDX_W = $clog2(NUM_LABELS);

    logic [vbd_pkg::CNT_W-1:0]    min_occupied_reg;
    logic                         pass_through_reg;
    logic                         s1_valid_reg;
    vbd_pkg::stage_t              s1_reg;

    logic                         accept;
    logic [vbd_pkg::LBL_W-1:0]    in_label;
    logic [vbd_pkg::CNT_W-1:0]    rd_data;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_idx;
    logic [vbd_pkg::CNT_W-1:0]    wr_data;
    logic                         res_valid;
    vbd_pkg::result_t             res;
    vbd_pkg::result_t             head;
    logic [vbd_pkg::Q_CNT_W-1:0]  q_count;
    logic                         q_not_empty;
    logic                         pop;

    assign in_label = s_tdata[vbd_pkg::LBL_W:1];
    // A voxel in the update stage may still need a queue slot.
    assign s_tready = ({1'b0, q_count} + (vbd_pkg::Q_CNT_W + 1)'(s1_valid_reg))
                      < (vbd_pkg::Q_CNT_W + 1)'(vbd_pkg::Q_DEPTH);
    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tready && q_not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_occupied_reg <= vbd_pkg::CNT_W'(1);
            pass_through_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                vbd_pkg::REG_MIN_OCCUPIED: min_occupied_reg <= cfg_data;
                vbd_pkg::REG_PASS_THROUGH: pass_through_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg.pass  <= pass_through_reg;
            s1_reg.last  <= s_tlast;
            s1_reg.occ   <= s_tdata[0];
            s1_reg.label <= in_label;
        end
    end

    vbd_vote_ram #(
        .DEPTH (NUM_LABELS),
        .IDX_W (IDX_W),
        .DW    (vbd_pkg::CNT_W)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_idx  (in_label[IDX_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data)
    );

    vbd_tally #(
        .MAX_BLOCK_VOXELS (MAX_BLOCK_VOXELS),
        .NUM_LABELS       (NUM_LABELS),
        .IDX_W            (IDX_W)
    ) u_tally (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .min_occupied (min_occupied_reg),
        .s1_valid     (s1_valid_reg),
        .s1           (s1_reg),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_idx       (wr_idx),
        .wr_data      (wr_data),
        .res_valid    (res_valid),
        .res          (res)
    );

    vbd_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head),
        .count     (q_count)
    );

    assign m_tvalid = q_not_empty;
    assign m_tdata  = vbd_pkg::M_TDATA_W'(head);

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(res_valid && !pop && (q_count == vbd_pkg::Q_CNT_W'(vbd_pkg::Q_DEPTH))))
        else $error("result pushed into a full queue");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_count == vbd_pkg::Q_CNT_W'(vbd_pkg::Q_DEPTH)) |-> !s_tready)
        else $error("input ready while result queue is full");

    a_pass_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && s1_reg.pass) |->
        ((res.coarse_label == s1_reg.label) &&
         (res.occupied_total == vbd_pkg::CNT_W'(s1_reg.occ))))
        else $error("pass-through result differs from its voxel");

    a_accept_to_update: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted voxel did not reach the update stage");

endmodule
`default_nettype wire
